>>> design/ccr_pkg.sv
package ccr_pkg;

    localparam int MAX_CYCLE_LEN = 64;
    localparam int ID_BITS       = 16;
    localparam int CNT_W         = $clog2(MAX_CYCLE_LEN + 1);
    localparam int ADDR_W        = $clog2(MAX_CYCLE_LEN);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // store an accepted pair, track the minimum
        logic rd_prev;  // read the vertex before the minimum
        logic rd_next;  // read the vertex after the minimum
        logic start;    // pick direction, read the first result
        logic step;     // result taken, read the next one
        logic clear;    // cycle done, return to the empty state
    } t_cmd;

    typedef struct packed {
        logic at_last;  // the result on show is the final one
    } t_sts;

endpackage

>>> design/ccr_in_if.sv
interface ccr_in_if import ccr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] vertex_id;
    logic [ID_BITS-1:0] edge_id;
    logic               is_last;

    modport source (output valid, output vertex_id, output edge_id, output is_last,
                    input ready);
    modport sink   (input valid, input vertex_id, input edge_id, input is_last,
                    output ready);
endinterface

>>> design/ccr_out_if.sv
interface ccr_out_if import ccr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] out_vertex;
    logic [ID_BITS-1:0] out_edge;
    logic               out_last;
    logic               overflow;

    modport source (output valid, output out_vertex, output out_edge, output out_last,
                    output overflow, input ready);
    modport sink   (input valid, input out_vertex, input out_edge, input out_last,
                    input overflow, output ready);
endinterface

>>> design/ccr_ram.sv
module ccr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ccr_datapath.sv
module ccr_datapath import ccr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [ID_BITS-1:0] i_vertex_id,
    input  logic [ID_BITS-1:0] i_edge_id,
    output t_sts               o_sts,
    output logic [ID_BITS-1:0] o_out_vertex,
    output logic [ID_BITS-1:0] o_out_edge,
    output logic               o_out_last,
    output logic               o_overflow
);

    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_min_pos;
    logic [ID_BITS-1:0] r_min_val;
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  r_vptr;
    logic [ADDR_W-1:0]  r_eptr;
    logic [ID_BITS-1:0] r_prev_v;
    logic               r_back;

    logic [CNT_W-1:0]   w_cnt_m1;
    logic [ADDR_W-1:0]  w_nm1;
    logic [ADDR_W-1:0]  w_prev_addr;
    logic [ADDR_W-1:0]  w_next_addr;
    logic               w_has_room;
    logic               w_we;
    logic               w_back_now;
    logic [ADDR_W-1:0]  n_vptr;
    logic [ADDR_W-1:0]  n_eptr;
    logic               w_v_re;
    logic               w_e_re;
    logic [ADDR_W-1:0]  w_v_raddr;
    logic [ADDR_W-1:0]  w_e_raddr;
    logic [ID_BITS-1:0] w_v_rdata;
    logic [ID_BITS-1:0] w_e_rdata;

    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_nm1       = w_cnt_m1[ADDR_W-1:0];
    assign w_prev_addr = (r_min_pos == '0) ? w_nm1 : r_min_pos - ADDR_W'(1);
    assign w_next_addr = (r_min_pos == w_nm1) ? '0 : r_min_pos + ADDR_W'(1);
    assign w_has_room  = r_count < CNT_W'(MAX_CYCLE_LEN);
    assign w_we        = i_cmd.load && w_has_room;

    // rdata holds the vertex after the minimum in the start cycle
    assign w_back_now  = r_prev_v < w_v_rdata;

    // Walk pointers wrap at n-1 in either direction
    always_comb begin
        if (r_back) begin
            n_vptr = (r_vptr == '0) ? w_nm1 : r_vptr - ADDR_W'(1);
            n_eptr = (r_eptr == '0) ? w_nm1 : r_eptr - ADDR_W'(1);
        end else begin
            n_vptr = (r_vptr == w_nm1) ? '0 : r_vptr + ADDR_W'(1);
            n_eptr = (r_eptr == w_nm1) ? '0 : r_eptr + ADDR_W'(1);
        end
    end

    always_comb begin
        w_v_re    = i_cmd.rd_prev || i_cmd.rd_next || i_cmd.start || i_cmd.step;
        w_e_re    = i_cmd.start || i_cmd.step;
        w_v_raddr = n_vptr;
        w_e_raddr = n_eptr;
        if (i_cmd.rd_prev) begin
            w_v_raddr = w_prev_addr;
        end else if (i_cmd.rd_next) begin
            w_v_raddr = w_next_addr;
        end else if (i_cmd.start) begin
            w_v_raddr = r_min_pos;
        end
        if (i_cmd.start) begin
            w_e_raddr = w_back_now ? w_prev_addr : r_min_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_min_pos <= '0;
            r_min_val <= '1;
            r_ovf     <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count   <= '0;
            r_min_pos <= '0;
            r_min_val <= '1;
            r_ovf     <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_has_room) begin
                if (r_count == '0 || i_vertex_id < r_min_val) begin
                    r_min_val <= i_vertex_id;
                    r_min_pos <= r_count[ADDR_W-1:0];
                end
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_next) begin
            r_prev_v <= w_v_rdata;
        end
        if (i_cmd.start) begin
            r_back <= w_back_now;
            r_vptr <= r_min_pos;
            r_eptr <= w_back_now ? w_prev_addr : r_min_pos;
            r_idx  <= '0;
        end else if (i_cmd.step) begin
            r_vptr <= n_vptr;
            r_eptr <= n_eptr;
            r_idx  <= r_idx + ADDR_W'(1);
        end
    end

    ccr_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CYCLE_LEN)) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_vertex_id),
        .i_re    (w_v_re),
        .i_raddr (w_v_raddr),
        .o_rdata (w_v_rdata)
    );

    ccr_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CYCLE_LEN)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_edge_id),
        .i_re    (w_e_re),
        .i_raddr (w_e_raddr),
        .o_rdata (w_e_rdata)
    );

    assign o_sts.at_last = (r_idx == w_nm1);
    assign o_out_vertex  = w_v_rdata;
    assign o_out_edge    = w_e_rdata;
    assign o_out_last    = (r_idx == w_nm1);
    assign o_overflow    = r_ovf;

endmodule

>>> design/ccr_ctrl.sv
module ccr_ctrl import ccr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRV,
        ST_NXT,
        ST_DIR,
        ST_SHOW
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_in_fire;
    logic   w_out_fire;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_SHOW);
    assign w_in_fire   = o_in_ready && i_in_valid;
    assign w_out_fire  = o_out_valid && i_out_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_in_fire;
        o_cmd.rd_prev = (r_state == ST_PRV);
        o_cmd.rd_next = (r_state == ST_NXT);
        o_cmd.start   = (r_state == ST_DIR);
        o_cmd.step    = w_out_fire;
        o_cmd.clear   = w_out_fire && i_sts.at_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_fire && i_in_last) begin
                    n_state = ST_PRV;
                end
            end
            ST_PRV:  n_state = ST_NXT;
            ST_NXT:  n_state = ST_DIR;
            ST_DIR:  n_state = ST_SHOW;
            ST_SHOW: begin
                if (w_out_fire && i_sts.at_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/cycle_canonical_rotation.sv
// Channel  Dir  Payload                                   Handshake
// i_in     in   vertex_id[16], edge_id[16], is_last       valid/ready
// o_out    out  out_vertex[16], out_edge[16], out_last,   valid/ready
//               overflow
//
// Loading accepts one pair per cycle; i_in.ready is high only while loading.
// After the last pair, the PRV, NXT and DIR states read the minimum's two
// neighbors through the single vertex RAM read port and pick the walk direction.
// Results leave at one per cycle while ready is high; the registered RAM
// outputs hold a stalled result, and the next read is issued only when a
// result is taken. Reset is synchronous; the stores need no clearing pass.
module cycle_canonical_rotation import ccr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ccr_in_if.sink   i_in,
    ccr_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    ccr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.is_last),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ccr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_vertex_id  (i_in.vertex_id),
        .i_edge_id    (i_in.edge_id),
        .o_sts        (w_sts),
        .o_out_vertex (o_out.out_vertex),
        .o_out_edge   (o_out.out_edge),
        .o_out_last   (o_out.out_last),
        .o_overflow   (o_out.overflow)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // Never take a pair while results are on show
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while output valid");

    // A closing pair yields the first result after the PRV, NXT and DIR states
    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.is_last) |-> ##4 o_out.valid)
        else $error("first result not shown on time");

    // Taking the final result reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.out_last) |=> i_in.ready)
        else $error("input not reopened after final result");

endmodule

>>> bench/ccr_rotation_checker.sv
`timescale 1ns / 1ps

module ccr_rotation_checker import ccr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [ID_BITS-1:0] i_in_vertex,
    input  logic [ID_BITS-1:0] i_in_edge,
    input  logic               i_in_last,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [ID_BITS-1:0] i_out_vertex,
    input  logic [ID_BITS-1:0] i_out_edge,
    input  logic               i_out_last,
    input  logic               i_out_overflow,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [ID_BITS-1:0] vertex;
        logic [ID_BITS-1:0] edge_id;
        logic               last;
        logic               ovf;
    } t_canon_pair;

    t_canon_pair        canon_q[$];
    logic [ID_BITS-1:0] vtx_mem [MAX_CYCLE_LEN];
    logic [ID_BITS-1:0] edg_mem [MAX_CYCLE_LEN];
    int unsigned        fill;
    int unsigned        min_pos;
    logic [ID_BITS-1:0] min_vtx;
    bit                 dropped;
    int                 fails = 0;
    int                 pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic check_field(input string name, input logic [ID_BITS-1:0] want,
                               input logic [ID_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_canon_pair want;
        int unsigned n, m, prv, nxt, vi, ei, k;
        bit          back;
        if (!i_rst_n) begin
            canon_q.delete();
            fill    = 0;
            min_pos = 0;
            min_vtx = '1;
            dropped = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (canon_q.size() == 0) begin
                    $display("%0t: result expected none actual %h %h last %b ovf %b",
                             $time, i_out_vertex, i_out_edge, i_out_last,
                             i_out_overflow);
                    fails++;
                end else begin
                    want = canon_q.pop_front();
                    check_field("out_vertex", want.vertex, i_out_vertex);
                    check_field("out_edge", want.edge_id, i_out_edge);
                    check_field("out_last", ID_BITS'(want.last), ID_BITS'(i_out_last));
                    check_field("overflow", ID_BITS'(want.ovf), ID_BITS'(i_out_overflow));
                end
            end
            if (i_in_valid && i_in_ready) begin
                // store while there is room, otherwise drop and flag
                if (fill < MAX_CYCLE_LEN) begin
                    if (fill == 0 || i_in_vertex < min_vtx) begin
                        min_vtx = i_in_vertex;
                        min_pos = fill;
                    end
                    vtx_mem[fill] = i_in_vertex;
                    edg_mem[fill] = i_in_edge;
                    fill++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in_last) begin
                    n = fill;
                    if (n != 0) begin
                        m    = min_pos % n;
                        prv  = (m + n - 1) % n;
                        nxt  = (m + 1) % n;
                        back = vtx_mem[prv] < vtx_mem[nxt];
                        for (k = 0; k < n; k++) begin
                            if (back) begin
                                vi = (m + n - k) % n;
                                ei = (m + 2 * n - k - 1) % n;
                            end else begin
                                vi = (m + k) % n;
                                ei = vi;
                            end
                            want.vertex  = vtx_mem[vi];
                            want.edge_id = edg_mem[ei];
                            want.last    = (k + 1 == n);
                            want.ovf     = dropped;
                            canon_q.push_back(want);
                        end
                    end
                    fill    = 0;
                    min_pos = 0;
                    min_vtx = '1;
                    dropped = 1'b0;
                end
            end
        end
        pending <= canon_q.size();
    end

endmodule

>>> bench/tb_cycle_canonical_rotation.sv
`timescale 1ns / 1ps

module tb_cycle_canonical_rotation;
    import ccr_pkg::*;

    localparam int          RANDOM_ITEMS = 430;
    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int          HOLD_CYCLES  = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned cycle_cnt  = 0;

    ccr_in_if  in_if ();
    ccr_out_if out_if ();

    cycle_canonical_rotation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ccr_rotation_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_if.valid),
        .i_in_ready     (in_if.ready),
        .i_in_vertex    (in_if.vertex_id),
        .i_in_edge      (in_if.edge_id),
        .i_in_last      (in_if.is_last),
        .i_out_valid    (out_if.valid),
        .i_out_ready    (out_if.ready),
        .i_out_vertex   (out_if.out_vertex),
        .i_out_edge     (out_if.out_edge),
        .i_out_last     (out_if.out_last),
        .i_out_overflow (out_if.overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one item; sometimes idle between bursts, keep valid high inside a burst.
    task automatic offer(input logic [ID_BITS-1:0] v, input logic [ID_BITS-1:0] e,
                         input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.vertex_id <= v;
        in_if.edge_id   <= e;
        in_if.is_last   <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Receiver: stretches of mixed stall patterns, one long hold-off mid run.
    initial begin : sink_side
        int  stretch, mode, k;
        bit  held;
        held = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            if (!held && items_sent >= 150) begin
                held = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge i_clk);
                    out_if.ready <= 1'b0;
                end
            end else begin
                stretch = $urandom_range(8, 64);
                mode    = $urandom_range(0, 2);
                for (k = 0; k < stretch; k++) begin
                    @(posedge i_clk);
                    case (mode)
                        0: out_if.ready <= 1'b1;
                        1: out_if.ready <= 1'($urandom_range(0, 1));
                        default: out_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial begin : source_side
        int                 cyc_no, len, sel, span, k, target;
        logic [ID_BITS-1:0] v;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.vertex_id <= '0;
        in_if.edge_id   <= '0;
        in_if.is_last   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single pair, all ones
        offer(16'hFFFF, 16'hFFFF, 1'b1);
        // two pairs: neighbors coincide, walk forward
        offer(16'h0000, 16'h0000, 1'b0);
        offer(16'hFFFF, 16'hFFFF, 1'b1);
        offer(16'h0005, 16'h0001, 1'b0);
        offer(16'h0002, 16'h0002, 1'b1);
        // minimum first, wrapped neighbor smaller: backward
        offer(16'h0001, 16'h000A, 1'b0);
        offer(16'h0009, 16'h000B, 1'b0);
        offer(16'h0004, 16'h000C, 1'b1);
        // minimum last, wrap on the next side
        offer(16'h0008, 16'h0014, 1'b0);
        offer(16'h0003, 16'h0015, 1'b0);
        offer(16'h0000, 16'h0016, 1'b1);
        // tie for the minimum: first one wins
        offer(16'h0007, 16'h001E, 1'b0);
        offer(16'h0002, 16'h001F, 1'b0);
        offer(16'h0009, 16'h0020, 1'b0);
        offer(16'h0002, 16'h0021, 1'b0);
        offer(16'h0005, 16'h0022, 1'b1);
        // equal neighbors: forward
        offer(16'h0004, 16'h0000, 1'b0);
        offer(16'h0001, 16'hFFFF, 1'b0);
        offer(16'h0004, 16'hAAAA, 1'b1);
        // all vertices equal
        offer(16'h0000, 16'h5555, 1'b0);
        offer(16'h0000, 16'hAAAA, 1'b0);
        offer(16'h0000, 16'h0F0F, 1'b1);

        target = items_sent + RANDOM_ITEMS;
        cyc_no = 0;
        while (items_sent < target) begin
            sel = $urandom_range(0, 99);
            if (cyc_no == 2)
                len = MAX_CYCLE_LEN + $urandom_range(1, 6);
            else if (cyc_no == 5)
                len = MAX_CYCLE_LEN;
            else if (sel < 4)
                len = MAX_CYCLE_LEN + $urandom_range(1, 8);
            else if (sel < 25)
                len = $urandom_range(11, MAX_CYCLE_LEN);
            else
                len = $urandom_range(1, 10);
            span = $urandom_range(0, 2);
            for (k = 0; k < len; k++) begin
                case (span)
                    0: v = ID_BITS'($urandom);
                    1: v = ID_BITS'($urandom_range(0, 7));
                    default: v = ($urandom_range(0, 1) == 0)
                                 ? ID_BITS'($urandom_range(0, 3))
                                 : (16'hFFFC | ID_BITS'($urandom_range(0, 3)));
                endcase
                offer(v, ID_BITS'($urandom), k == len - 1);
            end
            cyc_no++;
        end
        in_if.valid <= 1'b0;

        // let the checker see the last item before trusting its count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
design/ccr_pkg.sv
design/ccr_in_if.sv
design/ccr_out_if.sv
design/ccr_ram.sv
design/ccr_datapath.sv
design/ccr_ctrl.sv
design/cycle_canonical_rotation.sv
bench/ccr_rotation_checker.sv
bench/tb_cycle_canonical_rotation.sv
